[sv/stec_pkg.sv]
// shared types and constants for the spanning tree edge classifier
// no dependencies
`default_nettype none

package stec_pkg;

  // width of the endpoint node number fields
  localparam int unsigned END_W = 8;

  // default number of nodes in the parent memory
  localparam int unsigned NODES_DEF = 256;

  // result handed from the control unit to the output register
  typedef struct packed {
    logic valid;
    logic in_tree;
  } res_t;

endpackage

`default_nettype wire

[sv/spanning_tree_edge_classifier.sv]
// Spanning forest union-find edge classifier, top level with the output register.
// Each edge walks parent links from end_a and then from end_b through a one-read-port parent
// memory, one link per cycle, and links the root of end_a under the root of end_b when they
// differ. After reset, and before any item whose new_graph bit is set is handled, a clearing
// pass writes every memory entry, during which no item is accepted. A finished result waits in
// the output register while the next item is taken.
// depends on stec_pkg, stec_ctrl, stec_ram
`default_nettype none

module spanning_tree_edge_classifier #(
  parameter int unsigned NODES = stec_pkg::NODES_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output      logic                       in_ready_o,
  input  wire logic                       new_graph_i,
  input  wire logic [stec_pkg::END_W-1:0] end_a_i,
  input  wire logic [stec_pkg::END_W-1:0] end_b_i,
  output      logic                       out_valid_o,
  input  wire logic                       out_ready_i,
  output      logic                       in_tree_o
);

  import stec_pkg::*;

  localparam int unsigned NW = $clog2(NODES);

  res_t          res;
  logic          res_ready;
  logic          mem_we, mem_re;
  logic [NW-1:0] mem_waddr, mem_raddr;
  logic [NW:0]   mem_wdata, mem_rdata;

  logic out_valid_q, out_valid_d;
  logic in_tree_q, in_tree_d;

  stec_ctrl #(
    .NODES(NODES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .new_graph_i (new_graph_i),
    .end_a_i     (end_a_i),
    .end_b_i     (end_b_i),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  stec_ram #(
    .WIDTH(NW + 1),
    .DEPTH(NODES)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output slot is free when empty or being taken this cycle
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    in_tree_d   = in_tree_q;
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
      in_tree_d   = res.in_tree;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_tree_q <= in_tree_d;
  end

  assign out_valid_o = out_valid_q;
  assign in_tree_o   = in_tree_q;

endmodule

`default_nettype wire

[sv/stec_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module stec_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/stec_ctrl.sv]
// sequencer for the root walks, the link write and the clearing pass
// depends on stec_pkg; drives the parent memory in stec_ram
`default_nettype none

module stec_ctrl #(
  parameter int unsigned NODES = stec_pkg::NODES_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output      logic                       in_ready_o,
  input  wire logic                       new_graph_i,
  input  wire logic [stec_pkg::END_W-1:0] end_a_i,
  input  wire logic [stec_pkg::END_W-1:0] end_b_i,
  input  wire logic                       res_ready_i,
  output      stec_pkg::res_t             res_o,
  output      logic                       mem_we_o,
  output      logic [$clog2(NODES)-1:0]   mem_waddr_o,
  output      logic [$clog2(NODES):0]     mem_wdata_o,
  output      logic                       mem_re_o,
  output      logic [$clog2(NODES)-1:0]   mem_raddr_o,
  input  wire logic [$clog2(NODES):0]     mem_rdata_i
);

  import stec_pkg::*;

  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned CW = ((NW > END_W) ? NW : END_W) + 1;
  localparam logic [NW-1:0] LAST = NW'(NODES - 1);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_START  = 6'b000100,
    S_WALK_A = 6'b001000,
    S_WALK_B = 6'b010000,
    S_RESULT = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic            pend_q, pend_d;
  logic [NW-1:0]   clr_q, clr_d;
  logic [END_W-1:0] a_q, a_d, b_q, b_d;
  logic [NW-1:0]   node_q, node_d;
  logic [NW-1:0]   ra_q, ra_d;
  logic            tree_q, tree_d;

  logic            a_ok, b_ok;
  logic            link_valid;
  logic [NW-1:0]   link_node;

  // endpoints at or above the node count are ignored
  assign a_ok = CW'(a_q) < CW'(NODES);
  assign b_ok = CW'(b_q) < CW'(NODES);

  assign link_valid = mem_rdata_i[NW];
  assign link_node  = mem_rdata_i[NW-1:0];

  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    clr_d       = clr_q;
    a_d         = a_q;
    b_d         = b_q;
    node_d      = node_q;
    ra_d        = ra_q;
    tree_d      = tree_q;
    in_ready_o  = 1'b0;
    res_o       = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = ra_q;
    mem_wdata_o = {1'b1, node_q};
    mem_re_o    = 1'b0;
    mem_raddr_o = node_q;

    unique case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = '0;
        clr_d       = clr_q + 1'b1;
        if (clr_q == LAST) begin
          clr_d   = '0;
          pend_d  = 1'b0;
          state_d = pend_q ? S_START : S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          a_d     = end_a_i;
          b_d     = end_b_i;
          pend_d  = new_graph_i;
          state_d = new_graph_i ? S_CLEAR : S_START;
        end
      end
      S_START: begin
        if (a_ok && b_ok) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = NW'(a_q);
          node_d      = NW'(a_q);
          state_d     = S_WALK_A;
        end else begin
          tree_d  = 1'b0;
          state_d = S_RESULT;
        end
      end
      S_WALK_A: begin
        mem_re_o = 1'b1;
        if (link_valid) begin
          mem_raddr_o = link_node;
          node_d      = link_node;
        end else begin
          ra_d        = node_q;
          mem_raddr_o = NW'(b_q);
          node_d      = NW'(b_q);
          state_d     = S_WALK_B;
        end
      end
      S_WALK_B: begin
        if (link_valid) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = link_node;
          node_d      = link_node;
        end else begin
          // at the root of end_b: if the roots differ, hang the root of end_a under the root of end_b
          mem_we_o = (node_q != ra_q);
          tree_d   = (node_q != ra_q);
          state_d  = S_RESULT;
        end
      end
      S_RESULT: begin
        res_o.valid   = 1'b1;
        res_o.in_tree = tree_q;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      pend_q  <= 1'b0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    node_q <= node_d;
    ra_q   <= ra_d;
    tree_q <= tree_d;
  end

`ifndef SYNTHESIS
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o))
    else $error("parent memory read and written in the same cycle");

  a_link_not_self: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && state_q != S_CLEAR) |->
      (mem_wdata_o[NW] && mem_wdata_o[NW-1:0] != mem_waddr_o))
    else $error("link write must set a valid parent other than itself");

  // first result cycle only: the link write is in the cycle that ends the walk
  a_tree_means_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.in_tree && $past(state_q) == S_WALK_B) |-> $past(mem_we_o))
    else $error("tree edge reported without a link write");

  a_result_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_ready_i) |=> (state_q == S_IDLE))
    else $error("control did not return to idle after handing off the result");
`endif

endmodule

`default_nettype wire
